FILE: hdl/imu_cf_pkg.sv
`default_nettype none

package imu_cf_pkg;

  // CORDIC iteration count limits
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;

  // Field widths
  localparam int FIELD_W   = 16;
  localparam int ROLL_W    = 17;
  localparam int PITCH_W   = 16;
  localparam int YAW_W     = 17;
  localparam int BW_W      = 17;
  localparam int DT_W      = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;

  // CORDIC datapath widths: vector components and angle in 2^-16 degree
  localparam int CW = 28;
  localparam int AW = 26;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;

  // Filter mode codes
  localparam logic MODE_BLEND = 1'b0;
  localparam logic MODE_RAW   = 1'b1;

  // Register reset values
  localparam logic [BW_W-1:0] WEIGHT_RST = 17'd64225;
  localparam logic [DT_W-1:0] STEP_RST   = 16'd655;
  localparam logic [BW_W-1:0] WEIGHT_ONE = 17'd65536;

  // Angle limits in 1/256 degree
  localparam int ROLL_LIM  = 46080;
  localparam int PITCH_LIM = 23040;
  localparam int YAW_SPAN  = 92160;

  // One vector moving down the CORDIC chain
  typedef struct packed {
    logic                 vld;
    logic                 tag;
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
  } cordic_t;

  // atan(2^-idx) in 2^-16 degree
  function automatic logic signed [AW-1:0] cordic_atan(input int unsigned idx);
    logic signed [AW-1:0] v;
    case (idx)
      0:  v = AW'(2949120);
      1:  v = AW'(1740967);
      2:  v = AW'(919879);
      3:  v = AW'(466945);
      4:  v = AW'(234379);
      5:  v = AW'(117304);
      6:  v = AW'(58666);
      7:  v = AW'(29335);
      8:  v = AW'(14668);
      9:  v = AW'(7334);
      10: v = AW'(3667);
      11: v = AW'(1833);
      12: v = AW'(917);
      13: v = AW'(458);
      14: v = AW'(229);
      15: v = AW'(115);
      16: v = AW'(57);
      17: v = AW'(29);
      18: v = AW'(14);
      19: v = AW'(7);
      20: v = AW'(4);
      21: v = AW'(2);
      22: v = AW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/imu_cf_in_if.sv
`default_nettype none

interface imu_cf_in_if import imu_cf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] accel_x;
  logic signed [FIELD_W-1:0] accel_y;
  logic signed [FIELD_W-1:0] accel_z;
  logic signed [FIELD_W-1:0] rate_x;
  logic signed [FIELD_W-1:0] rate_y;
  logic signed [FIELD_W-1:0] rate_z;

  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/imu_cf_out_if.sv
`default_nettype none

interface imu_cf_out_if import imu_cf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ROLL_W-1:0]  roll_out;
  logic signed [PITCH_W-1:0] pitch_out;
  logic signed [YAW_W-1:0]   yaw_out;

  modport source (output valid, roll_out, pitch_out, yaw_out, input ready);
  modport sink (input valid, roll_out, pitch_out, yaw_out, output ready);
endinterface

`default_nettype wire

FILE: hdl/imu_cf_cell.sv
`default_nettype none

module imu_cf_cell import imu_cf_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  cordic_t cell_i,
  output cordic_t cell_o
);

  localparam logic signed [AW-1:0] ATAN = cordic_atan(STEP);

  cordic_t              cell_d;
  cordic_t              cell_q;
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;

  // One vectoring micro-rotation: drive y toward zero
  always_comb begin
    sx     = cell_i.x >>> STEP;
    sy     = cell_i.y >>> STEP;
    cell_d = cell_i;
    if (!cell_i.y[CW-1]) begin
      cell_d.x = cell_i.x + sy;
      cell_d.y = cell_i.y - sx;
      cell_d.z = cell_i.z + ATAN;
    end else begin
      cell_d.x = cell_i.x - sy;
      cell_d.y = cell_i.y + sx;
      cell_d.z = cell_i.z - ATAN;
    end
  end

  // Hand the vector on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

FILE: hdl/imu_complementary_attitude_filter.sv
// The roll vector enters the CORDIC cell chain on the input transfer; then the
// squares, the 24-step square root, the pitch vector pass through the chain and
// the rate and blend steps run, and no new sample is taken until the block is idle.
// The next sample is taken while a finished result waits for its transfer.
// Reset (rst_ni low, asynchronous) clears the angles to zero and loads the
// registers with mode complementary, weight 64225 and step time 655.
`default_nettype none

module imu_complementary_attitude_filter import imu_cf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  imu_cf_in_if.sink                   in_i,
  imu_cf_out_if.source                out_o,
  input  wire                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i
);

  localparam int NSTEP = (CORDIC_STEPS > CORDIC_STEPS_MAX) ? CORDIC_STEPS_MAX : CORDIC_STEPS;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_SQ1  = 10'b0000000010,
    ST_SQ2  = 10'b0000000100,
    ST_SQRT = 10'b0000001000,
    ST_PINJ = 10'b0000010000,
    ST_WAIT = 10'b0000100000,
    ST_RATE = 10'b0001000000,
    ST_GSUM = 10'b0010000000,
    ST_PROD = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } state_e;

  state_e st_q, st_d;

  // Configuration registers
  logic            mode_q;
  logic [BW_W-1:0] weight_q;
  logic [DT_W-1:0] dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BLEND;
      weight_q <= WEIGHT_RST;
      dt_q     <= STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        CFG_WEIGHT: weight_q <= cfg_data_i[BW_W-1:0];
        CFG_STEP:   dt_q     <= cfg_data_i[DT_W-1:0];
        default:    ;
      endcase
    end
  end

  logic in_xfer, out_xfer;
  assign in_i.ready = (st_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;

  // Latched sample
  logic signed [FIELD_W-1:0] ax_q, ay_q, az_q, rx_q, ry_q, rz_q;

  // Square root datapath
  logic [31:0] sq_q;
  logic [47:0] rem_q, res_q, bit_q;
  logic [47:0] trial;
  logic [31:0] sq_sum;
  logic signed [31:0] ay_sq, az_sq;

  assign ay_sq  = 32'(ay_q) * 32'(ay_q);
  assign az_sq  = 32'(az_q) * 32'(az_q);
  assign sq_sum = sq_q + 32'(az_sq);
  assign trial  = res_q + bit_q;

  // CORDIC chain input with quadrant pre-rotation
  cordic_t              link [NSTEP+1];
  logic signed [CW-1:0] vx, vy;
  logic signed [16:0]   neg_ax;

  assign neg_ax = -(17'(ax_q));

  always_comb begin
    link[0] = '0;
    if (st_q == ST_PINJ) begin
      link[0].vld = 1'b1;
      link[0].tag = 1'b1;
      vx = CW'({1'b0, res_q[24:0]});
      vy = CW'(signed'({neg_ax, 8'h00}));
    end else begin
      link[0].vld = in_xfer;
      link[0].tag = 1'b0;
      vx = CW'(signed'({in_i.accel_z, 8'h00}));
      vy = CW'(signed'({in_i.accel_y, 8'h00}));
    end
    link[0].zero = (vx == '0) && (vy == '0);
    link[0].x    = vx;
    link[0].y    = vy;
    link[0].z    = '0;
    if (vx[CW-1]) begin
      if (!vy[CW-1]) begin
        link[0].x = vy;
        link[0].y = -vx;
        link[0].z = AW'(90 * 65536);
      end else begin
        link[0].x = -vy;
        link[0].y = vx;
        link[0].z = -AW'(90 * 65536);
      end
    end
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_cell
    imu_cf_cell #(.STEP(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[g]),
      .cell_o (link[g+1])
    );
  end

  logic signed [AW-1:0] chain_z;
  assign chain_z = link[NSTEP].zero ? '0 : link[NSTEP].z;

  // Blend datapath
  logic signed [AW-1:0]  acc_r_q, acc_p_q;
  logic signed [32:0]    rdt_r_q, rdt_p_q, rdt_y_q;
  logic signed [33:0]    g_r_q, g_p_q;
  logic signed [18:0]    dyaw_q;
  logic signed [51:0]    pw_r_q, pw_p_q;
  logic signed [49:0]    pa_r_q, pa_p_q;
  logic [BW_W-1:0]       w_cl;
  logic signed [17:0]    w_s, wc_s;
  logic signed [16:0]    dt_s;
  logic signed [31:0]    a_r, a_p;

  assign w_cl = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;
  assign w_s  = signed'({1'b0, w_cl});
  assign wc_s = signed'({1'b0, WEIGHT_ONE - w_cl});
  assign dt_s = signed'({1'b0, dt_q});
  assign a_r  = 32'(acc_r_q) <<< 6;
  assign a_p  = 32'(acc_p_q) <<< 6;

  // Angle state
  logic signed [ROLL_W-1:0]  roll_q;
  logic signed [PITCH_W-1:0] pitch_q;
  logic signed [YAW_W-1:0]   yaw_q;

  // Final blend, raw path, saturation and yaw wrap
  logic signed [52:0] s_r, s_p;
  logic signed [22:0] b_r, b_p;
  logic signed [17:0] raw_r, raw_p;
  logic signed [22:0] pre_r, pre_p;
  logic signed [ROLL_W-1:0]  roll_n;
  logic signed [PITCH_W-1:0] pitch_n;
  logic signed [20:0] ysum, ym, ywr;
  logic signed [YAW_W-1:0]   yaw_n;

  always_comb begin
    s_r   = 53'(pw_r_q) + 53'(pa_r_q) + 53'(64'sd536870912);
    s_p   = 53'(pw_p_q) + 53'(pa_p_q) + 53'(64'sd536870912);
    b_r   = 23'(s_r >>> 30);
    b_p   = 23'(s_p >>> 30);
    raw_r = 18'((acc_r_q + AW'(128)) >>> 8);
    raw_p = 18'((acc_p_q + AW'(128)) >>> 8);
    pre_r = (mode_q == MODE_RAW) ? 23'(raw_r) : b_r;
    pre_p = (mode_q == MODE_RAW) ? 23'(raw_p) : b_p;
    if (pre_r > 23'(ROLL_LIM))        roll_n = ROLL_W'(ROLL_LIM);
    else if (pre_r < -23'(ROLL_LIM))  roll_n = -ROLL_W'(ROLL_LIM);
    else                              roll_n = ROLL_W'(pre_r);
    if (pre_p > 23'(PITCH_LIM))       pitch_n = PITCH_W'(PITCH_LIM);
    else if (pre_p < -23'(PITCH_LIM)) pitch_n = -PITCH_W'(PITCH_LIM);
    else                              pitch_n = PITCH_W'(pre_p);
    ysum = 21'(yaw_q) + 21'(dyaw_q);
    ym   = ysum + 21'(ROLL_LIM);
    if (ym >= 21'(2 * YAW_SPAN))  ywr = ym - 21'(2 * YAW_SPAN);
    else if (ym >= 21'(YAW_SPAN)) ywr = ym - 21'(YAW_SPAN);
    else if (ym >= 21'sd0)        ywr = ym;
    else if (ym >= -21'(YAW_SPAN)) ywr = ym + 21'(YAW_SPAN);
    else                          ywr = ym + 21'(2 * YAW_SPAN);
    yaw_n = YAW_W'(ywr - 21'(ROLL_LIM));
  end

  // Sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_xfer) st_d = ST_SQ1;
      ST_SQ1:  st_d = ST_SQ2;
      ST_SQ2:  st_d = ST_SQRT;
      ST_SQRT: if (bit_q[0]) st_d = ST_PINJ;
      ST_PINJ: st_d = ST_WAIT;
      ST_WAIT: if (link[NSTEP].vld && link[NSTEP].tag) st_d = ST_RATE;
      ST_RATE: st_d = ST_GSUM;
      ST_GSUM: st_d = ST_PROD;
      ST_PROD: st_d = ST_FIN;
      ST_FIN:  if (!out_o.valid || out_o.ready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // Control state, angle state and result register valid
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      out_vld_q <= 1'b0;
      roll_q    <= '0;
      pitch_q   <= '0;
      yaw_q     <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_FIN && (!out_vld_q || out_o.ready)) begin
        out_vld_q <= 1'b1;
        roll_q    <= roll_n;
        pitch_q   <= pitch_n;
        yaw_q     <= yaw_n;
      end else if (out_xfer) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ax_q <= in_i.accel_x;
      ay_q <= in_i.accel_y;
      az_q <= in_i.accel_z;
      rx_q <= in_i.rate_x;
      ry_q <= in_i.rate_y;
      rz_q <= in_i.rate_z;
    end
    if (st_q == ST_SQ1) begin
      sq_q <= 32'(ay_sq);
    end
    if (st_q == ST_SQ2) begin
      rem_q <= {sq_sum, 16'h0000};
      res_q <= '0;
      bit_q <= 48'h1 << 46;
    end
    // One bit of the integer square root per cycle
    if (st_q == ST_SQRT) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    // Collect CORDIC angles by tag
    if (link[NSTEP].vld) begin
      if (link[NSTEP].tag) acc_p_q <= chain_z;
      else                 acc_r_q <= chain_z;
    end
    if (st_q == ST_RATE) begin
      rdt_r_q <= 33'(rx_q) * 33'(dt_s);
      rdt_p_q <= 33'(ry_q) * 33'(dt_s);
      rdt_y_q <= 33'(rz_q) * 33'(dt_s);
    end
    if (st_q == ST_GSUM) begin
      g_r_q  <= (34'(roll_q) <<< 14) + 34'(rdt_r_q);
      g_p_q  <= (34'(pitch_q) <<< 14) + 34'(rdt_p_q);
      dyaw_q <= 19'((rdt_y_q + 33'sd8192) >>> 14);
    end
    if (st_q == ST_PROD) begin
      pw_r_q <= 52'(w_s) * 52'(g_r_q);
      pw_p_q <= 52'(w_s) * 52'(g_p_q);
      pa_r_q <= 50'(wc_s) * 50'(a_r);
      pa_p_q <= 50'(wc_s) * 50'(a_p);
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.roll_out  = roll_q;
  assign out_o.pitch_out = pitch_q;
  assign out_o.yaw_out   = yaw_q;

  // A transfer in leaves the block busy in the next cycle.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("input ready high right after a transfer");

  // A new result appears only out of the final step.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(st_q == ST_FIN))
    else $error("result valid rose outside the final step");

  // Roll and yaw results stay within their angle ranges.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (roll_q <= 17'(ROLL_LIM) && roll_q >= -17'(ROLL_LIM) &&
                   yaw_q <= 17'(ROLL_LIM - 1) && yaw_q >= -17'(ROLL_LIM)))
    else $error("result angle out of range");

endmodule

`default_nettype wire

FILE: sim/imu_cf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module imu_cf_checker import imu_cf_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  imu_cf_in_if.sink  in_mon,
  imu_cf_out_if.sink out_mon,
  input  wire        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [YAW_W-1:0]   yaw;
  } attitude_t;

  // Shadow registers and attitude state of the filter.
  logic              mode_q;
  logic [BW_W-1:0]   weight_q;
  logic [DT_W-1:0]   step_q;
  longint            roll_q, pitch_q, yaw_q;
  attitude_t         attitude_q[$];

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'd1 << 48;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC: atan2(y, x) in 2^-16 degree.
  function automatic longint atan2_deg16(longint x, longint y);
    longint table_atan[24];
    longint acc, t, nx, ny;
    table_atan = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115,
                   57, 29, 14, 7, 4, 2, 1, 0};
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; acc = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; acc = -90 * 65536;
      end
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (y >= 0) begin
        nx = x + shr(y, i); ny = y - shr(x, i); acc += table_atan[i];
      end else begin
        nx = x - shr(y, i); ny = y + shr(x, i); acc -= table_atan[i];
      end
      x = nx; y = ny;
    end
    return acc;
  endfunction

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint mix(longint angle, longint rate, longint dt,
                                 longint acc16, longint w);
    longint g, s;
    g = angle * 16384 + rate * dt;
    s = w * g + (65536 - w) * (acc16 * 64);
    return shr(s + (64'd1 << 29), 30);
  endfunction

  // Predict the attitude for every accepted sample.
  always @(posedge clk_i or negedge rst_ni) begin
    longint ax, ay, az, rx, ry, rz, dt, w, a_roll, a_pitch, m;
    if (!rst_ni) begin
      mode_q <= MODE_BLEND; weight_q <= WEIGHT_RST; step_q <= STEP_RST;
      roll_q <= 0; pitch_q <= 0; yaw_q <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:   mode_q <= cfg_data_i[0];
          CFG_WEIGHT: weight_q <= cfg_data_i[BW_W-1:0];
          CFG_STEP:   step_q <= cfg_data_i[DT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        ax = in_mon.accel_x; ay = in_mon.accel_y; az = in_mon.accel_z;
        rx = in_mon.rate_x; ry = in_mon.rate_y; rz = in_mon.rate_z;
        dt = step_q;
        w = (weight_q > WEIGHT_ONE) ? 65536 : weight_q;
        a_roll = atan2_deg16(az * 256, ay * 256);
        a_pitch = atan2_deg16(int_sqrt((ay * ay + az * az) << 16), -ax * 256);
        if (mode_q == MODE_BLEND) begin
          roll_q = clamp(mix(roll_q, rx, dt, a_roll, w), ROLL_LIM);
          pitch_q = clamp(mix(pitch_q, ry, dt, a_pitch, w), PITCH_LIM);
        end else begin
          roll_q = clamp(shr(a_roll + 128, 8), ROLL_LIM);
          pitch_q = clamp(shr(a_pitch + 128, 8), PITCH_LIM);
        end
        m = (yaw_q + shr(rz * dt + 8192, 14) + ROLL_LIM) % YAW_SPAN;
        if (m < 0) m += YAW_SPAN;
        yaw_q = m - ROLL_LIM;
        attitude_q.push_back('{ROLL_W'(roll_q), PITCH_W'(pitch_q), YAW_W'(yaw_q)});
      end
    end
  end

  // Compare each result transfer with the oldest prediction.
  initial fail_count_o = 0;
  always @(posedge clk_i) begin
    attitude_t exp_a;
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      if (attitude_q.size() == 0) begin
        $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d", $time,
                 out_mon.roll_out, out_mon.pitch_out, out_mon.yaw_out);
        fail_count_o++;
      end else begin
        exp_a = attitude_q.pop_front();
        if (exp_a.roll !== out_mon.roll_out) begin
          $display("%0t: roll expected %0d actual %0d", $time, exp_a.roll, out_mon.roll_out);
          fail_count_o++;
        end
        if (exp_a.pitch !== out_mon.pitch_out) begin
          $display("%0t: pitch expected %0d actual %0d", $time, exp_a.pitch,
                   out_mon.pitch_out);
          fail_count_o++;
        end
        if (exp_a.yaw !== out_mon.yaw_out) begin
          $display("%0t: yaw expected %0d actual %0d", $time, exp_a.yaw, out_mon.yaw_out);
          fail_count_o++;
        end
      end
    end
  end

  assign pending_o = attitude_q.size();

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import imu_cf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_MODE;
  logic [CFG_W-1:0] cfg_data_i = '0;
  int fail_count, pending;
  bit calm_phase = 1'b0;
  bit hold_off = 1'b0;
  bit sending_done = 1'b0;

  imu_cf_in_if  sample_ch ();
  imu_cf_out_if attitude_ch ();

  imu_complementary_attitude_filter DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(sample_ch.sink), .out_o(attitude_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  imu_cf_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(sample_ch.sink), .out_mon(attitude_ch.sink),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    sample_ch.valid = 1'b0;
    {sample_ch.accel_x, sample_ch.accel_y, sample_ch.accel_z} = '0;
    {sample_ch.rate_x, sample_ch.rate_y, sample_ch.rate_z} = '0;
    attitude_ch.ready = 1'b0;
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) attitude_ch.ready <= 1'b0;
    else if (calm_phase) attitude_ch.ready <= 1'b1;
    else attitude_ch.ready <= ($urandom_range(99) >= 13);
  end

  initial begin
    wait (rst_ni);
    repeat (3000) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One sample transfer, with random gaps before it unless calm.
  task automatic send_sample(input logic [FIELD_W-1:0] ax, ay, az, rx, ry, rz);
    while (!calm_phase && $urandom_range(99) < 13) begin
      @(posedge clk_i);
      sample_ch.valid <= 1'b0;
    end
    @(posedge clk_i);
    sample_ch.valid <= 1'b1;
    sample_ch.accel_x <= ax; sample_ch.accel_y <= ay; sample_ch.accel_z <= az;
    sample_ch.rate_x <= rx; sample_ch.rate_y <= ry; sample_ch.rate_z <= rz;
    do @(posedge clk_i); while (!sample_ch.ready);
    sample_ch.valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [FIELD_W-1:0] rand_field();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return FIELD_W'($urandom_range(64)) - 16'd32;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Random samples; mostly gravity-like vectors with random tilt.
  task automatic random_burst(input int n);
    logic [FIELD_W-1:0] ax, ay, az;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0) begin
        ax = FIELD_W'($urandom_range(16000)) - 16'd8000;
        ay = FIELD_W'($urandom_range(16000)) - 16'd8000;
        az = FIELD_W'($urandom_range(20000)) - 16'd4000;
      end else begin
        ax = rand_field(); ay = rand_field(); az = rand_field();
      end
      send_sample(ax, ay, az, rand_field(), rand_field(), rand_field());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: zero vector, extremes, quadrants, near-180 roll.
    send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'd0, 16'd1, 16'hFC00, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(16'd0, 16'hFFFF, 16'hFC00, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_sample(16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
    send_sample(16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
    send_sample(16'd0, 16'd4000, 16'd0, 16'd64, 16'hFFC0, 16'd1);
    drain();
    write_reg(CFG_MODE, CFG_W'(MODE_RAW));
    write_reg(CFG_STEP, 17'd0);
    send_sample(16'd100, 16'hFF00, 16'hF000, 16'd5, 16'd5, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'd5, 16'd5, 16'h8000);
    drain();
    write_reg(CFG_MODE, CFG_W'(MODE_BLEND));
    write_reg(CFG_WEIGHT, 17'h1FFFF);
    write_reg(CFG_STEP, 17'd65535);
    send_sample(16'd0, 16'd0, 16'd4000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'd0, 16'd0, 16'd4000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    drain();
    write_reg(CFG_WEIGHT, 17'd0);
    write_reg(CFG_STEP, 17'd1);
    send_sample(16'd10, 16'd0, 16'hF000, 16'd0, 16'd0, 16'd1);
    drain();
    // Random phases over several settings.
    write_reg(CFG_WEIGHT, CFG_W'(WEIGHT_RST));
    write_reg(CFG_STEP, CFG_W'(STEP_RST));
    random_burst(200);
    drain();
    calm_phase = 1'b1;
    write_reg(CFG_WEIGHT, 17'd65536);
    write_reg(CFG_STEP, 17'd65535);
    random_burst(120);
    drain();
    calm_phase = 1'b0;
    write_reg(CFG_MODE, CFG_W'(MODE_RAW));
    write_reg(CFG_STEP, CFG_W'($urandom_range(65535, 1)));
    random_burst(150);
    drain();
    write_reg(CFG_MODE, CFG_W'(MODE_BLEND));
    write_reg(CFG_WEIGHT, CFG_W'($urandom_range(65536)));
    write_reg(CFG_STEP, CFG_W'($urandom_range(65535, 1)));
    random_burst(150);
    drain();
    write_reg(CFG_WEIGHT, CFG_W'($urandom_range(131071, 65537)));
    write_reg(CFG_STEP, CFG_W'($urandom_range(2000, 1)));
    random_burst(120);
    drain();
    if (fail_count == 0) $display("** imu_complementary_attitude_filter: PASSED **");
    else $display("** imu_complementary_attitude_filter: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** imu_complementary_attitude_filter: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

FILE: imu_complementary_attitude_filter.f
hdl/imu_cf_pkg.sv
hdl/imu_cf_in_if.sv
hdl/imu_cf_out_if.sv
hdl/imu_cf_cell.sv
hdl/imu_complementary_attitude_filter.sv
sim/imu_cf_checker.sv
sim/testbench.sv
